[rtl/iems_pkg.sv]
// Package for the I2C EEPROM master sequencer: bus phases, commands, status codes.
// No dependencies.
package iems_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_START  = 4'd1,
    PH_RSTART = 4'd2,
    PH_SDEV   = 4'd3,
    PH_SMEM   = 4'd4,
    PH_SDATA  = 4'd5,
    PH_SDEVR  = 4'd6,
    PH_ADEV   = 4'd7,
    PH_AMEM   = 4'd8,
    PH_ADATA  = 4'd9,
    PH_ADEVR  = 4'd10,
    PH_READ   = 4'd11,
    PH_MACK   = 4'd12,
    PH_STOP   = 4'd13,
    PH_WAIT   = 4'd14
  } phase_t;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_PUSH  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOACK  = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;

  localparam logic [1:0] CFG_DEV     = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_WAIT    = 2'd2;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       rd_last;
    logic       busy;
    logic       done;
    logic [1:0] status;
  } result_t;

endpackage

[rtl/iems_core.sv]
// Bus sequencer core: advances the I2C bus at most a quarter bit per tick.
// Depends on iems_pkg.
module iems_core #(
  parameter int PAGE_BYTES = 8,
  parameter int MEM_BYTES  = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [1:0]          command,
  input  logic [1:0]          operation,
  input  logic [7:0]          mem_address,
  input  logic [8:0]          length,
  input  logic [7:0]          data_byte,
  input  logic                sda_in,
  input  logic [7:0]          dev_addr,
  input  logic [7:0]          ack_tmo,
  input  logic [19:0]         wait_ticks,
  output iems_pkg::result_t   res
);

  localparam int PW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
  localparam int FW = $clog2(PAGE_BYTES + 1);

  iems_pkg::phase_t phase, phase_next;
  logic [1:0]  qstep, qstep_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [19:0] wait_count, wait_count_next;
  logic [FW-1:0] buffer_fill, buffer_fill_next;
  logic [1:0]  current_op, current_op_next;
  logic [7:0]  address_reg, address_reg_next;
  logic [6:0]  data_pos, data_pos_next;
  logic        err_flag, err_flag_next;
  logic        scl_q, scl_next, sda_q, sda_next;
  logic [7:0]  page_buffer [PAGE_BYTES];
  logic        buf_we;
  iems_pkg::result_t res_next;
  logic [7:0]  buf_rd;
  logic [8:0]  poll_inc;
  logic [8:0]  bytes_dec;

  assign buf_rd = (data_pos < 7'(PAGE_BYTES)) ? page_buffer[data_pos[PW-1:0]] : 8'd0;
  assign poll_inc = {1'b0, poll_count} + 9'd1;
  assign bytes_dec = bytes_left - 9'd1;

  always_comb begin
    phase_next = phase; qstep_next = qstep; bit_count_next = bit_count;
    shift_reg_next = shift_reg; bytes_left_next = bytes_left;
    poll_count_next = poll_count; wait_count_next = wait_count;
    buffer_fill_next = buffer_fill; current_op_next = current_op;
    address_reg_next = address_reg; data_pos_next = data_pos;
    err_flag_next = err_flag; scl_next = scl_q; sda_next = sda_q;
    buf_we = 1'b0;
    res_next = '0;

    if (command == iems_pkg::CMD_PUSH) begin
      if (phase == iems_pkg::PH_IDLE && buffer_fill < FW'(PAGE_BYTES)) begin
        buf_we = 1'b1;
        buffer_fill_next = buffer_fill + 1'b1;
      end
    end else if (command == iems_pkg::CMD_START) begin
      if (phase == iems_pkg::PH_IDLE && operation != 2'd3) begin
        current_op_next = operation;
        address_reg_next = mem_address;
        bytes_left_next = length;
        err_flag_next = 1'b0;
        data_pos_next = '0;
        if (operation == iems_pkg::OP_WRITE) buffer_fill_next = '0;
        if ((operation == iems_pkg::OP_WRITE && length > 9'(PAGE_BYTES)) ||
            (operation == iems_pkg::OP_READ && {1'b0, length} > 10'(MEM_BYTES))) begin
          qstep_next = '0;
          res_next.done = 1'b1;
          res_next.status = iems_pkg::ST_LENGTH;
        end else begin
          phase_next = iems_pkg::PH_START;
          qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
        end
      end
    end else begin
      unique case (phase)
        iems_pkg::PH_IDLE: ;
        iems_pkg::PH_WAIT: begin
          if (wait_count != '0) wait_count_next = wait_count - 1'b1;
          if (wait_count <= 20'd1) begin
            phase_next = iems_pkg::PH_IDLE; qstep_next = '0;
            res_next.done = 1'b1;
          end
        end
        iems_pkg::PH_START, iems_pkg::PH_RSTART: begin
          qstep_next = qstep + 1'b1;
          case (qstep)
            2'd0: sda_next = 1'b1;
            2'd1: scl_next = 1'b1;
            2'd2: sda_next = 1'b0;
            default: begin
              scl_next = 1'b0;
              shift_reg_next = (phase == iems_pkg::PH_START) ? dev_addr : (dev_addr | 8'h01);
              phase_next = (phase == iems_pkg::PH_START) ? iems_pkg::PH_SDEV
                                                         : iems_pkg::PH_SDEVR;
              qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
            end
          endcase
        end
        iems_pkg::PH_SDEV, iems_pkg::PH_SMEM, iems_pkg::PH_SDATA, iems_pkg::PH_SDEVR: begin
          qstep_next = qstep + 1'b1;
          case (qstep)
            2'd0: begin scl_next = 1'b0; sda_next = shift_reg[7]; end
            2'd1: scl_next = 1'b1;
            2'd2: ;
            default: begin
              scl_next = 1'b0;
              shift_reg_next = {shift_reg[6:0], 1'b0};
              bit_count_next = bit_count + 1'b1;
              if (bit_count >= 4'd7) begin
                phase_next = iems_pkg::phase_t'(phase + 4'd4);
                qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
              end
            end
          endcase
        end
        iems_pkg::PH_ADEV, iems_pkg::PH_AMEM, iems_pkg::PH_ADATA, iems_pkg::PH_ADEVR: begin
          if (qstep == 2'd0) begin
            sda_next = 1'b1; scl_next = 1'b0; qstep_next = 2'd1;
          end else if (qstep == 2'd1) begin
            scl_next = 1'b1; qstep_next = 2'd2;
          end else if (!sda_in) begin
            scl_next = 1'b0;
            qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
            // The next phase depends on which acknowledge just arrived.
            case (phase)
              iems_pkg::PH_ADEV: begin
                if (current_op == iems_pkg::OP_PROBE) phase_next = iems_pkg::PH_STOP;
                else begin
                  shift_reg_next = address_reg; phase_next = iems_pkg::PH_SMEM;
                end
              end
              iems_pkg::PH_AMEM: begin
                if (current_op == iems_pkg::OP_READ) phase_next = iems_pkg::PH_RSTART;
                else if (bytes_left != '0) begin
                  shift_reg_next = buf_rd; data_pos_next = data_pos + 1'b1;
                  phase_next = iems_pkg::PH_SDATA;
                end else phase_next = iems_pkg::PH_STOP;
              end
              iems_pkg::PH_ADATA: begin
                bytes_left_next = bytes_dec;
                if (bytes_dec != '0) begin
                  shift_reg_next = buf_rd; data_pos_next = data_pos + 1'b1;
                  phase_next = iems_pkg::PH_SDATA;
                end else phase_next = iems_pkg::PH_STOP;
              end
              default: begin
                if (bytes_left != '0) begin
                  shift_reg_next = '0; phase_next = iems_pkg::PH_READ;
                end else phase_next = iems_pkg::PH_STOP;
              end
            endcase
          end else if (poll_inc > {1'b0, ack_tmo}) begin
            err_flag_next = 1'b1;
            phase_next = iems_pkg::PH_STOP;
            qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
          end else begin
            poll_count_next = poll_inc[7:0];
          end
        end
        iems_pkg::PH_READ: begin
          qstep_next = qstep + 1'b1;
          case (qstep)
            2'd0: begin scl_next = 1'b0; sda_next = 1'b1; end
            2'd1: scl_next = 1'b1;
            2'd2: shift_reg_next = {shift_reg[6:0], sda_in};
            default: begin
              scl_next = 1'b0;
              bit_count_next = bit_count + 1'b1;
              if (bit_count >= 4'd7) begin
                res_next.rd_valid = 1'b1;
                res_next.rd_byte = shift_reg;
                res_next.rd_last = (bytes_left == 9'd1);
                phase_next = iems_pkg::PH_MACK;
                qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
              end
            end
          endcase
        end
        iems_pkg::PH_MACK: begin
          qstep_next = qstep + 1'b1;
          case (qstep)
            2'd0: begin scl_next = 1'b0; sda_next = (bytes_left == 9'd1); end
            2'd1: scl_next = 1'b1;
            2'd2: ;
            default: begin
              scl_next = 1'b0;
              bytes_left_next = bytes_dec;
              qstep_next = '0; bit_count_next = '0; poll_count_next = '0;
              if (bytes_dec == '0) phase_next = iems_pkg::PH_STOP;
              else begin
                shift_reg_next = '0; phase_next = iems_pkg::PH_READ;
              end
            end
          endcase
        end
        iems_pkg::PH_STOP: begin
          qstep_next = qstep + 1'b1;
          case (qstep)
            2'd0: begin scl_next = 1'b0; sda_next = 1'b0; end
            2'd1: scl_next = 1'b1;
            2'd2: sda_next = 1'b1;
            default: begin
              qstep_next = '0;
              if (err_flag) begin
                phase_next = iems_pkg::PH_IDLE;
                res_next.done = 1'b1; res_next.status = iems_pkg::ST_NOACK;
              end else if (current_op == iems_pkg::OP_WRITE && wait_ticks != '0) begin
                wait_count_next = wait_ticks;
                phase_next = iems_pkg::PH_WAIT;
              end else begin
                phase_next = iems_pkg::PH_IDLE;
                res_next.done = 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
    res_next.scl = scl_next;
    res_next.sda = sda_next;
    res_next.busy = (phase_next != iems_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (step && buf_we) page_buffer[buffer_fill[PW-1:0]] <= data_byte;
    if (step) res <= res_next;
    if (rst) begin
      phase <= iems_pkg::PH_IDLE; qstep <= '0; bit_count <= '0; shift_reg <= '0;
      bytes_left <= '0; poll_count <= '0; wait_count <= '0; buffer_fill <= '0;
      current_op <= iems_pkg::OP_PROBE; address_reg <= '0; data_pos <= '0;
      err_flag <= 1'b0; scl_q <= 1'b1; sda_q <= 1'b1;
    end else if (step) begin
      phase <= phase_next; qstep <= qstep_next; bit_count <= bit_count_next;
      shift_reg <= shift_reg_next; bytes_left <= bytes_left_next;
      poll_count <= poll_count_next; wait_count <= wait_count_next;
      buffer_fill <= buffer_fill_next; current_op <= current_op_next;
      address_reg <= address_reg_next; data_pos <= data_pos_next;
      err_flag <= err_flag_next; scl_q <= scl_next; sda_q <= sda_next;
    end
  end

endmodule

[rtl/i2c_eeprom_master_sequencer.sv]
// Top level of the I2C EEPROM master sequencer: configuration registers,
// request handshake and result register around iems_core. Depends on iems_pkg.
//
// Each request (tick, data push or start) is handled by the sequencer core and
// yields one result, held in an output register until taken; a new request is
// accepted every cycle while the result register is empty or being drained.
// One tick moves the bus by at most a quarter bit period.
module i2c_eeprom_master_sequencer #(
  parameter int PAGE_BYTES = 8,
  parameter int MEM_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [1:0]  operation,
  input  logic [7:0]  mem_address,
  input  logic [8:0]  length,
  input  logic [7:0]  data_byte,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        read_valid,
  output logic [7:0]  read_byte,
  output logic        read_last,
  output logic        busy_res,
  output logic        done_res,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  logic [7:0]  device_address;
  logic [7:0]  ack_timeout;
  logic [19:0] write_wait_ticks;
  logic        step;
  iems_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign in_stall = out_valid && out_stall;
  assign step = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd160;
      ack_timeout <= 8'd250;
      write_wait_ticks <= 20'd10000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        iems_pkg::CFG_DEV:     device_address <= cfg_data[7:0];
        iems_pkg::CFG_TIMEOUT: ack_timeout <= cfg_data[7:0];
        iems_pkg::CFG_WAIT:    write_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (step) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  iems_core #(.PAGE_BYTES(PAGE_BYTES), .MEM_BYTES(MEM_BYTES)) u_core (
    .clk, .rst, .step, .command, .operation, .mem_address, .length, .data_byte,
    .sda_in, .dev_addr(device_address), .ack_tmo(ack_timeout),
    .wait_ticks(write_wait_ticks), .res
  );

  assign scl_level = res.scl;
  assign sda_level = res.sda;
  assign read_valid = res.rd_valid;
  assign read_byte = res.rd_byte;
  assign read_last = res.rd_last;
  assign busy_res = res.busy;
  assign done_res = res.done;
  assign status = res.status;

endmodule

[rtl/iems_checker.sv]
// Port-level checks for the I2C EEPROM master sequencer, bound to the top level.
// Depends on iems_pkg and the top level's ports.
module iems_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       read_valid,
  input logic       read_last,
  input logic [7:0] read_byte,
  input logic       done_res,
  input logic [1:0] status
);

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_byte) && $stable(status))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("request gave no result");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_last |-> read_valid)
    else $error("last flag without read byte");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == iems_pkg::ST_OK)
    else $error("status without done");

endmodule

bind i2c_eeprom_master_sequencer iems_checker u_iems_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .read_valid,
  .read_last, .read_byte, .done_res, .status
);
